@@ rtl/core/wpt_pkg.sv @@
`timescale 1ns / 1ps

package wpt_pkg;

  localparam int HELD_DEPTH  = 16;
  localparam int PUNCT_SLOTS = 8;

  localparam int CODE_W  = 16;
  localparam int REG_W   = 64;
  localparam int CNT_W   = $clog2(HELD_DEPTH + 1);
  localparam int HELD_AW = (HELD_DEPTH > 1) ? $clog2(HELD_DEPTH) : 1;

  // output tdata: item_code, overflow_seen, zero pad to whole bytes
  localparam int OUT_TDATA_W = ((CODE_W + 1 + 7) / 8) * 8;

  typedef enum logic [1:0] {
    REG_CODES_LOW  = 2'd0,
    REG_CODES_HIGH = 2'd1,
    REG_COUNT      = 2'd2
  } reg_idx_t;

  typedef enum logic [1:0] {
    KIND_WORD  = 2'd0,
    KIND_PUNCT = 2'd1,
    KIND_END   = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_FLUSH,
    S_TAIL
  } state_t;

endpackage

@@ rtl/core/word_punctuation_tokenizer_top.sv @@
`timescale 1ns / 1ps
// A result beat is registered and shows on the master side in the cycle after its
// input beat; a first result from the held run passes the flush state, the
// registered memory read and the output register, and the output can stall there.
// Throughput: one character per cycle while no held run is flushed and no output
// beat is stalled. The held run sits in a memory with a registered read.
// Reset (sync, active high) clears state, flags, held count and config; the held run
// memory is not cleared, only entries below the held count are ever read.
module word_punctuation_tokenizer_top (
  input  logic                                clk,
  input  logic                                rst,
  // s_tdata: char_code[15:0]
  input  logic [wpt_pkg::CODE_W-1:0]          s_tdata,
  input  logic                                s_tlast,   // end_of_text
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // m_tdata: item_code[15:0], overflow_seen[16], zero pad
  output logic [wpt_pkg::OUT_TDATA_W-1:0]     m_tdata,
  output logic [1:0]                          m_tuser,   // item_kind
  output logic                                m_tlast,   // last_of_run
  output logic                                m_tvalid,
  input  logic                                m_tready,
  input  logic                                cfg_we,
  input  logic [1:0]                          cfg_addr,
  input  logic [wpt_pkg::REG_W-1:0]           cfg_data
);
  import wpt_pkg::*;

  // config
  logic [REG_W-1:0] codes_low;
  logic [REG_W-1:0] codes_high;
  logic [3:0]       punct_count;

  // control state
  state_t             state, state_next;
  logic               in_word, in_word_next;
  logic [CNT_W-1:0]   held_count, held_count_next;
  logic               overflow, overflow_next;
  logic [HELD_AW-1:0] rd_idx, rd_idx_next;
  logic               rd_valid, rd_valid_next;
  kind_t              flush_kind, flush_kind_next;
  logic [CODE_W-1:0]  tail_code, tail_code_next;

  // output register
  logic               out_valid, out_valid_next;
  kind_t              out_kind, out_kind_next;
  logic [CODE_W-1:0]  out_code, out_code_next;
  logic               out_last, out_last_next;
  logic               out_ovf, out_ovf_next;

  // held run memory
  logic [CODE_W-1:0]  held_mem [HELD_DEPTH];
  logic               mem_we;
  logic               rd_en;
  logic [HELD_AW-1:0] rd_addr;
  logic [CODE_W-1:0]  rd_data;

  logic [2*REG_W-1:0] codes_all;
  logic               out_free;
  logic               accept;
  logic               is_space;
  logic               is_punct;
  logic               last_entry;

  assign codes_all = {codes_high, codes_low};
  assign out_free  = !out_valid || m_tready;
  assign s_tready  = (state == S_IDLE) && out_free;
  assign accept    = s_tvalid && s_tready;
  assign is_space  = (s_tdata inside {[16'd9:16'd13], 16'd32});
  assign last_entry = ((CNT_W'(rd_idx) + 1'b1) == held_count);

  always_comb begin
    is_punct = 1'b0;
    for (int i = 0; i < PUNCT_SLOTS; i++) begin
      if ((4'(i) < punct_count) && (codes_all[CODE_W*i +: CODE_W] == s_tdata)) begin
        is_punct = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      codes_low   <= '0;
      codes_high  <= '0;
      punct_count <= '0;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_CODES_LOW:  codes_low   <= cfg_data;
        REG_CODES_HIGH: codes_high  <= cfg_data;
        REG_COUNT:      punct_count <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    state_next      = state;
    in_word_next    = in_word;
    held_count_next = held_count;
    overflow_next   = overflow;
    rd_idx_next     = rd_idx;
    rd_valid_next   = rd_valid;
    flush_kind_next = flush_kind;
    tail_code_next  = tail_code;
    out_valid_next  = out_valid && !m_tready;
    out_kind_next   = out_kind;
    out_code_next   = out_code;
    out_last_next   = out_last;
    out_ovf_next    = out_ovf;
    mem_we          = 1'b0;
    rd_en           = 1'b0;
    rd_addr         = rd_idx;

    case (state)
      S_IDLE: begin
        if (accept) begin
          if ((s_tlast && in_word) || (!s_tlast && in_word && is_space)) begin
            // close the word: marker, then held run as punctuation
            out_valid_next = 1'b1;
            out_kind_next  = KIND_END;
            out_code_next  = '0;
            out_last_next  = (held_count == '0);
            out_ovf_next   = overflow;
            in_word_next   = 1'b0;
            if (held_count != '0) begin
              flush_kind_next = KIND_PUNCT;
              rd_idx_next     = '0;
              rd_valid_next   = 1'b0;
              state_next      = S_FLUSH;
            end
          end else if (!s_tlast && !in_word && !is_space) begin
            out_valid_next = 1'b1;
            out_code_next  = s_tdata;
            out_last_next  = 1'b1;
            out_ovf_next   = overflow;
            if (is_punct) begin
              out_kind_next = KIND_PUNCT;
            end else begin
              out_kind_next = KIND_WORD;
              in_word_next  = 1'b1;
            end
          end else if (!s_tlast && in_word && is_punct) begin
            if (held_count < CNT_W'(HELD_DEPTH)) begin
              mem_we          = 1'b1;
              held_count_next = held_count + 1'b1;
            end else begin
              overflow_next = 1'b1;
            end
          end else if (!s_tlast && in_word) begin
            if (held_count == '0) begin
              out_valid_next = 1'b1;
              out_kind_next  = KIND_WORD;
              out_code_next  = s_tdata;
              out_last_next  = 1'b1;
              out_ovf_next   = overflow;
            end else begin
              // held run joins the word, then this char
              tail_code_next  = s_tdata;
              flush_kind_next = KIND_WORD;
              rd_idx_next     = '0;
              rd_valid_next   = 1'b0;
              state_next      = S_FLUSH;
            end
          end
        end
      end
      S_FLUSH: begin
        if (!rd_valid) begin
          rd_en         = 1'b1;
          rd_valid_next = 1'b1;
        end else if (out_free) begin
          out_valid_next = 1'b1;
          out_kind_next  = flush_kind;
          out_code_next  = rd_data;
          out_last_next  = last_entry && (flush_kind == KIND_PUNCT);
          out_ovf_next   = overflow;
          if (last_entry) begin
            held_count_next = '0;
            rd_valid_next   = 1'b0;
            state_next      = (flush_kind == KIND_WORD) ? S_TAIL : S_IDLE;
          end else begin
            rd_idx_next = rd_idx + 1'b1;
            rd_addr     = rd_idx + 1'b1;
            rd_en       = 1'b1;
          end
        end
      end
      S_TAIL: begin
        if (out_free) begin
          out_valid_next = 1'b1;
          out_kind_next  = KIND_WORD;
          out_code_next  = tail_code;
          out_last_next  = 1'b1;
          out_ovf_next   = overflow;
          state_next     = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      in_word    <= 1'b0;
      held_count <= '0;
      overflow   <= 1'b0;
      rd_valid   <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      in_word    <= in_word_next;
      held_count <= held_count_next;
      overflow   <= overflow_next;
      rd_valid   <= rd_valid_next;
      out_valid  <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    rd_idx     <= rd_idx_next;
    flush_kind <= flush_kind_next;
    tail_code  <= tail_code_next;
    out_kind   <= out_kind_next;
    out_code   <= out_code_next;
    out_last   <= out_last_next;
    out_ovf    <= out_ovf_next;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      held_mem[held_count[HELD_AW-1:0]] <= s_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= held_mem[rd_addr];
    end
  end

  assign m_tvalid = out_valid;
  assign m_tuser  = out_kind;
  assign m_tlast  = out_last;
  assign m_tdata  = {{(OUT_TDATA_W - CODE_W - 1){1'b0}}, out_ovf, out_code};

endmodule

@@ rtl/core/wpt_checker.sv @@
`timescale 1ns / 1ps
module wpt_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_tready,
  input logic [wpt_pkg::OUT_TDATA_W-1:0] m_tdata,
  input logic [1:0]                      m_tuser,
  input logic                            m_tlast,
  input logic                            m_tvalid,
  input logic                            m_tready
);
  import wpt_pkg::*;

  logic ovf_beat_seen;

  always_ff @(posedge clk) begin
    if (rst) begin
      ovf_beat_seen <= 1'b0;
    end else if (m_tvalid && m_tready && m_tdata[CODE_W]) begin
      ovf_beat_seen <= 1'b1;
    end
  end

  // stalled beat holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
      && $stable(m_tlast))
    else $error("stalled output beat changed");

  // input is blocked while an output beat is stalled
  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |-> !s_tready)
    else $error("input ready while output stalled");

  // overflow flag is sticky across beats
  a_ovf_sticky: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && ovf_beat_seen |-> m_tdata[CODE_W])
    else $error("overflow flag dropped");

  // word-end marker carries code zero
  a_end_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == KIND_END) |-> (m_tdata[CODE_W-1:0] == '0))
    else $error("end marker with nonzero code");

  // no output right after reset
  a_reset: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid after reset");

endmodule

bind word_punctuation_tokenizer_top wpt_checker u_wpt_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready)
);

@@ bench/word_punctuation_tokenizer_top_test.sv @@
`timescale 1ns / 1ps

module word_punctuation_tokenizer_top_test;
  import wpt_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 24;

  localparam logic [1:0] REG_UNUSED = 2'd3;
  localparam logic [15:0] CH_TAB = 16'd9;
  localparam logic [15:0] CH_CR = 16'd13;
  localparam logic [15:0] CH_SPACE = 16'd32;
  localparam logic [16:0] EOT = 17'h10000;

  // slot 0 '.', 1 ',', 2 '!', 3 '?'; slot 4 tab, 5 '-', 6 ':', 7 ';'
  localparam logic [63:0] CODES_LO_STD = 64'h003F_0021_002C_002E;
  localparam logic [63:0] CODES_HI_STD = 64'h003B_003A_002D_0009;
  localparam logic [63:0] CODES_LO_ALT = 64'h0027_0029_0028_0022;
  localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

  typedef struct {
    kind_t kind;
    logic [15:0] code;
    logic last;
    logic ovf;
  } token_t;

  class token_scoreboard;
    logic [63:0] codes_lo;
    logic [63:0] codes_hi;
    logic [3:0] slot_count;
    bit in_word;
    bit overflow;
    logic [15:0] held_q[$];
    token_t run_q[$];
    token_t expected_q[$];
    int errors;

    function new();
      codes_lo = '0;
      codes_hi = '0;
      slot_count = '0;
      in_word = 0;
      overflow = 0;
      errors = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [63:0] val);
      case (idx)
        REG_CODES_LOW: codes_lo = val;
        REG_CODES_HIGH: codes_hi = val;
        REG_COUNT: slot_count = val[3:0];
        default: ;
      endcase
    endfunction

    function int slots_used();
      return (slot_count > PUNCT_SLOTS) ? PUNCT_SLOTS : int'(slot_count);
    endfunction

    function logic [15:0] slot_code(int i);
      logic [63:0] w;
      w = (i < 4) ? codes_lo : codes_hi;
      return w[16 * (i % 4) +: 16];
    endfunction

    function bit is_space(logic [15:0] c);
      return (c >= CH_TAB && c <= CH_CR) || c == CH_SPACE;
    endfunction

    function bit is_punct(logic [15:0] c);
      for (int i = 0; i < slots_used(); i++)
        if (slot_code(i) == c) return 1;
      return 0;
    endfunction

    function void emit(kind_t k, logic [15:0] c);
      token_t t;
      t.kind = k;
      t.code = c;
      t.last = 0;
      t.ovf = 0;
      run_q = {run_q, t};
    endfunction

    function void flush_held(kind_t k);
      foreach (held_q[i]) emit(k, held_q[i]);
      held_q.delete();
    endfunction

    function void close_word();
      emit(KIND_END, 16'h0000);
      flush_held(KIND_PUNCT);
      in_word = 0;
    endfunction

    // accepted character beat -> expected output beats
    function void take_char(logic [15:0] c, logic eot);
      run_q.delete();
      if (eot) begin
        if (in_word) close_word();
      end else if (!in_word) begin
        if (!is_space(c)) begin
          if (is_punct(c)) begin
            emit(KIND_PUNCT, c);
          end else begin
            in_word = 1;
            emit(KIND_WORD, c);
          end
        end
      end else if (is_space(c)) begin
        close_word();
      end else if (is_punct(c)) begin
        if (held_q.size() < HELD_DEPTH) held_q = {held_q, c};
        else overflow = 1;
      end else begin
        flush_held(KIND_WORD);
        emit(KIND_WORD, c);
      end
      foreach (run_q[i]) begin
        run_q[i].ovf = overflow;
        run_q[i].last = (i == run_q.size() - 1);
        expected_q = {expected_q, run_q[i]};
      end
    endfunction

    function void check_field(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        $error("%s: expected %0h, got %0h", name, want, got);
        errors++;
      end
    endfunction

    function void check_item(logic [1:0] kind, logic [15:0] code, logic last, logic ovf);
      token_t e;
      if (expected_q.size() == 0) begin
        $error("output beat with nothing expected: kind %0h code %0h", kind, code);
        errors++;
        return;
      end
      e = expected_q[0];
      expected_q.delete(0);
      check_field("item_kind", 16'(e.kind), 16'(kind));
      check_field("item_code", e.code, code);
      check_field("last_of_run", 16'(e.last), 16'(last));
      check_field("overflow_seen", 16'(e.ovf), 16'(ovf));
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic [CODE_W-1:0] s_tdata = '0;
  logic s_tlast = 1'b0;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic [1:0] m_tuser;
  logic m_tlast;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_addr = '0;
  logic [REG_W-1:0] cfg_data = '0;

  token_scoreboard sb = new();
  int sender_idle_pct = 0;
  int sink_stall_pct = 0;
  int chars_sent = 0;
  int cycles = 0;

  logic [16:0] directed_seq[$] = '{
    17'h00020, 17'h0002E, 17'h00041, 17'h0002C, 17'h00021, 17'h00062,
    17'h0003F, 17'h0003B, 17'h00020, 17'h0FFFF, 17'h00000, 17'h00009,
    17'h0000D, 17'h00078, 17'h0002D, EOT | 17'h0FFFF, EOT, 17'h0000E,
    17'h00008, 17'h0000A, 17'h00071, 17'h0000B, 17'h0000C, 17'h0003A,
    17'h0007A, 17'h0002E, EOT
  };

  word_punctuation_tokenizer_top uut (
    .clk(clk),
    .rst(rst),
    .s_tdata(s_tdata),
    .s_tlast(s_tlast),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser),
    .m_tlast(m_tlast),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .cfg_we(cfg_we),
    .cfg_addr(cfg_addr),
    .cfg_data(cfg_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    m_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
  end

  // input beats are noted before output beats are checked at the same edge
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) sb.take_char(s_tdata, s_tlast);
      if (m_tvalid && m_tready) sb.check_item(m_tuser, m_tdata[15:0], m_tlast, m_tdata[16]);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic send_beat(input logic [15:0] code, input logic eot);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= code;
    s_tlast <= eot;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic wait_drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [63:0] val);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= val;
    @(posedge clk);
    sb.write_reg(idx, val);
  endtask

  task automatic apply_setting(input int p);
    case (p)
      1: begin
        write_reg(REG_CODES_LOW, CODES_LO_STD);
        write_reg(REG_CODES_HIGH, CODES_HI_STD);
        write_reg(REG_COUNT, 64'd0);
      end
      2: begin
        // count 15 clamps to all slots; codes are 16'hFFFF and 16'h0000
        write_reg(REG_CODES_LOW, ALL_ONES);
        write_reg(REG_CODES_HIGH, 64'd0);
        write_reg(REG_COUNT, ALL_ONES);
      end
      3: begin
        write_reg(REG_CODES_LOW, CODES_LO_STD);
        write_reg(REG_CODES_HIGH, CODES_HI_STD);
        write_reg(REG_COUNT, 64'd1);
        write_reg(REG_UNUSED, ALL_ONES);
      end
      4: begin
        write_reg(REG_CODES_HIGH, ALL_ONES);
        write_reg(REG_COUNT, 64'hFFFF_FFFF_FFFF_FFF5);
      end
      6: begin
        write_reg(REG_CODES_LOW, CODES_LO_ALT);
        write_reg(REG_CODES_HIGH, CODES_HI_STD);
        write_reg(REG_COUNT, 64'd7);
      end
      7: begin
        write_reg(REG_CODES_LOW, CODES_LO_STD);
        write_reg(REG_CODES_HIGH, ALL_ONES);
        write_reg(REG_COUNT, 64'd8);
      end
      default: begin
        write_reg(REG_CODES_LOW, CODES_LO_STD);
        write_reg(REG_CODES_HIGH, CODES_HI_STD);
        write_reg(REG_COUNT, 64'd8);
      end
    endcase
    cfg_we <= 1'b0;
  endtask

  function automatic logic [15:0] rand_letter();
    return ($urandom_range(0, 1) ? 16'h0041 : 16'h0061) + 16'($urandom_range(0, 25));
  endfunction

  function automatic logic [15:0] rand_space();
    int k;
    k = $urandom_range(0, 5);
    return (k == 5) ? CH_SPACE : CH_TAB + 16'(k);
  endfunction

  function automatic logic [15:0] rand_punct();
    int n;
    n = sb.slots_used();
    if (n == 0) return rand_letter();
    return sb.slot_code($urandom_range(0, n - 1));
  endfunction

  // long runs can go past the held depth and trip the sticky overflow
  task automatic send_punct_run(input bit allow_long);
    int len;
    if (allow_long && $urandom_range(0, 7) == 0) len = $urandom_range(14, 20);
    else len = $urandom_range(1, 3);
    repeat (len) send_beat(rand_punct(), 1'b0);
    chars_sent += len;
  endtask

  task automatic send_text(input int n_items, input bit allow_long);
    int target;
    int pick;
    int len;
    target = chars_sent + n_items;
    while (chars_sent < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 12) begin
        send_beat(16'($urandom), $urandom_range(0, 9) == 0);
        chars_sent++;
      end else begin
        len = $urandom_range(1, 6);
        for (int i = 0; i < len; i++) begin
          if (i > 0 && $urandom_range(0, 3) == 0) send_punct_run(allow_long);
          send_beat(rand_letter(), 1'b0);
          chars_sent++;
        end
        pick = $urandom_range(0, 99);
        if (pick >= 50 && pick < 90) send_punct_run(allow_long);
        if (pick < 75) send_beat(rand_space(), 1'b0);
        else send_beat(16'($urandom), 1'b1);
        chars_sent++;
      end
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int p = 0; p < 8; p++) begin
      wait_drain();
      apply_setting(p);
      case (p % 4)
        0: begin
          sender_idle_pct = 0;
          sink_stall_pct = 0;
        end
        1: begin
          sender_idle_pct = 60;
          sink_stall_pct = 0;
        end
        2: begin
          sender_idle_pct = 0;
          sink_stall_pct = 60;
        end
        default: begin
          sender_idle_pct = 19;
          sink_stall_pct = 19;
        end
      endcase
      if (p == 0) begin
        foreach (directed_seq[i]) send_beat(directed_seq[i][15:0], directed_seq[i][16]);
      end
      send_text(28, p >= 5);
      wait_drain();
      send_text(28, p >= 5);
    end
    wait_drain();

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/core/wpt_pkg.sv
rtl/core/word_punctuation_tokenizer_top.sv
rtl/core/wpt_checker.sv
bench/word_punctuation_tokenizer_top_test.sv
